>>> rtl/dvs_pkg.sv
// dvs_pkg: shared types and constants of the dual valve sequencer
// field widths, register reset values, register indexes and valve codes
// no dependencies
package dvs_pkg;

  // field widths
  localparam int DEMAND_W     = 16;
  localparam int POS_W        = 12;
  localparam int CMD_W        = 11;
  localparam int STEP_PER_W   = 20;
  localparam int SWITCH_PER_W = 24;
  localparam int OT_W         = 8;
  localparam int CFG_W        = 24;
  localparam int CFG_IDX_W    = 2;

  // register reset values
  localparam logic [STEP_PER_W-1:0]   STEP_PERIOD_RESET   = 20'd1210;
  localparam logic [SWITCH_PER_W-1:0] SWITCH_PERIOD_RESET = 24'd333333;
  localparam logic [OT_W-1:0]         OVERTRAVEL_RESET    = 8'd4;
  localparam logic [POS_W-1:0]        MAX_POSITION_RESET  = 12'd1000;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD   = 2'd0,
    CFG_SWITCH_PERIOD = 2'd1,
    CFG_OVERTRAVEL    = 2'd2,
    CFG_MAX_POSITION  = 2'd3
  } cfg_index_t;

  // directional valve positions
  typedef enum logic [1:0] {
    VALVE_CLOSE   = 2'd0,
    VALVE_EXTEND  = 2'd1,
    VALVE_RETRACT = 2'd2
  } valve_pos_t;

  // settings shared by both stepper channels
  typedef struct packed {
    logic [STEP_PER_W-1:0] step_period;
    logic [OT_W-1:0]       overtravel;
    logic [POS_W-1:0]      max_position;
  } stepper_cfg_t;

  // demand converted to half-steps, sign and magnitude
  typedef struct packed {
    logic             neg;
    logic [CMD_W-1:0] mag;
  } half_steps_t;

endpackage

>>> rtl/dvs_stepper.sv
// dvs_stepper: one stepper valve channel with its position, step and direction state
// takes one half-step toward its target per step period, with closing overtravel
// depends on dvs_pkg
module dvs_stepper #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic [dvs_pkg::POS_W-1:0] target,
  input  logic [TIME_BITS-1:0]      now,
  input  dvs_pkg::stepper_cfg_t     cfg,
  output logic [dvs_pkg::POS_W-1:0] position,
  output logic                      step_level,
  output logic                      direction
);

  localparam int CMP_W = (TIME_BITS > dvs_pkg::STEP_PER_W) ? TIME_BITS : dvs_pkg::STEP_PER_W;

  logic [dvs_pkg::OT_W-1:0]  overtravel_left;
  logic [TIME_BITS-1:0]      last_time;

  logic [dvs_pkg::POS_W-1:0] position_next;
  logic                      step_level_next;
  logic                      direction_next;
  logic [dvs_pkg::OT_W-1:0]  overtravel_left_next;
  logic [TIME_BITS-1:0]      last_time_next;
  logic [TIME_BITS-1:0]      elapsed;
  logic                      period_done;

  // wrapping elapsed time against the step period
  assign elapsed     = now - last_time;
  assign period_done = CMP_W'(elapsed) >= CMP_W'(cfg.step_period);

  // half-step decision
  always_comb begin
    position_next        = position;
    step_level_next      = step_level;
    direction_next       = direction;
    overtravel_left_next = overtravel_left;
    last_time_next       = last_time;
    if (position != target) begin
      if (period_done) begin
        last_time_next = now;
        if (position < target) begin
          // opening stalls at the top position
          if (position < cfg.max_position) begin
            direction_next       = 1'b0;
            position_next        = position + dvs_pkg::POS_W'(1);
            step_level_next      = ~step_level;
            overtravel_left_next = cfg.overtravel;
          end
        end else begin
          direction_next  = 1'b1;
          step_level_next = ~step_level;
          // overtravel half-steps are spent at position one
          if (position == dvs_pkg::POS_W'(1) && overtravel_left != '0) begin
            overtravel_left_next = overtravel_left - dvs_pkg::OT_W'(1);
          end else begin
            position_next        = position - dvs_pkg::POS_W'(1);
            overtravel_left_next = cfg.overtravel;
          end
        end
      end
    end else begin
      overtravel_left_next = cfg.overtravel;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= '0;
      step_level      <= 1'b0;
      direction       <= 1'b0;
      overtravel_left <= dvs_pkg::OVERTRAVEL_RESET;
      last_time       <= '0;
    end else if (advance) begin
      position        <= position_next;
      step_level      <= step_level_next;
      direction       <= direction_next;
      overtravel_left <= overtravel_left_next;
      last_time       <= last_time_next;
    end
  end

endmodule

>>> rtl/dual_valve_dcv_sequencer_top.sv
// dual_valve_dcv_sequencer_top: top level of the dual valve and directional valve sequencer
// input register, command conversion, directional valve control and result transfer
// depends on dvs_pkg and dvs_stepper
//
// Usage
//   input channel: in_valid / in_stall carry two Q7.8 percent demands and a
//   microsecond time; a transfer takes place when in_valid is high and
//   in_stall low. output channel: out_valid / out_stall carry one result per
//   input item, being the stepper and directional valve state after that item.
//   configuration: cfg_write with cfg_index and cfg_data writes one register;
//   write only while no item is in flight.
// Pipeline and throughput
//   an item transferred into the input register moves on into the state
//   registers, which double as the result register, once the result held
//   there is taken or none is held. one item per cycle is sustained while
//   out_stall stays low; the input register and the state registers set
//   that figure.
// Reset
//   synchronous, active high: steppers at position zero, valve closed, coils
//   off, registers at 1210 us, 333333 us, 4 overtravel steps, max 1000.
// Stall
//   a stalled result holds; one further item waits in the input register,
//   after which in_stall goes high until the result is taken.
module dual_valve_dcv_sequencer_top #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_write,
  input  logic [dvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dvs_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [dvs_pkg::DEMAND_W-1:0] demand_one,
  input  logic signed [dvs_pkg::DEMAND_W-1:0] demand_two,
  input  logic [TIME_BITS-1:0]           now_us,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           first_step_level,
  output logic                           first_direction,
  output logic [dvs_pkg::POS_W-1:0]      first_position,
  output logic                           second_step_level,
  output logic                           second_direction,
  output logic [dvs_pkg::POS_W-1:0]      second_position,
  output logic                           coil_a,
  output logic                           coil_b,
  output logic [1:0]                     switch_position
);

  localparam int CMP_W = (TIME_BITS > dvs_pkg::SWITCH_PER_W) ? TIME_BITS : dvs_pkg::SWITCH_PER_W;

  // demand to half-steps: round(demand * 10 / 256), halves away from zero
  function automatic dvs_pkg::half_steps_t to_half_steps(
    input logic [dvs_pkg::DEMAND_W-1:0] bits
  );
    dvs_pkg::half_steps_t res;
    logic [dvs_pkg::DEMAND_W:0]   mag;
    logic [dvs_pkg::DEMAND_W+3:0] scaled;
    res.neg = bits[dvs_pkg::DEMAND_W-1];
    if (res.neg) begin
      mag = (17'h10000 - {1'b0, bits});
    end else begin
      mag = {1'b0, bits};
    end
    scaled  = ({3'b000, mag} << 3) + ({3'b000, mag} << 1) + 20'd128;
    res.mag = scaled[dvs_pkg::CMD_W+7:8];
    return res;
  endfunction

  // configuration registers
  dvs_pkg::stepper_cfg_t            step_cfg;
  logic [dvs_pkg::SWITCH_PER_W-1:0] switch_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cfg.step_period  <= dvs_pkg::STEP_PERIOD_RESET;
      switch_period         <= dvs_pkg::SWITCH_PERIOD_RESET;
      step_cfg.overtravel   <= dvs_pkg::OVERTRAVEL_RESET;
      step_cfg.max_position <= dvs_pkg::MAX_POSITION_RESET;
    end else if (cfg_write) begin
      unique case (dvs_pkg::cfg_index_t'(cfg_index))
        dvs_pkg::CFG_STEP_PERIOD:
          step_cfg.step_period <= cfg_data[dvs_pkg::STEP_PER_W-1:0];
        dvs_pkg::CFG_SWITCH_PERIOD:
          switch_period <= cfg_data[dvs_pkg::SWITCH_PER_W-1:0];
        dvs_pkg::CFG_OVERTRAVEL:
          step_cfg.overtravel <= cfg_data[dvs_pkg::OT_W-1:0];
        dvs_pkg::CFG_MAX_POSITION:
          step_cfg.max_position <= cfg_data[dvs_pkg::POS_W-1:0];
      endcase
    end
  end

  // handshake: input register and result register
  logic                         s1_valid;
  logic [dvs_pkg::DEMAND_W-1:0] s1_demand_one;
  logic [dvs_pkg::DEMAND_W-1:0] s1_demand_two;
  logic [TIME_BITS-1:0]         s1_now;
  logic                         out_free;
  logic                         fire;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign fire     = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_demand_one <= demand_one;
      s1_demand_two <= demand_two;
      s1_now        <= now_us;
    end
  end

  // command conversion and sign resolution
  dvs_pkg::half_steps_t     cmd_one;
  dvs_pkg::half_steps_t     cmd_two;
  logic [dvs_pkg::CMD_W-1:0] mag_one;
  logic [dvs_pkg::CMD_W-1:0] mag_two;
  logic                      pos_one;
  logic                      neg_one;
  logic                      pos_two;
  logic                      neg_two;
  dvs_pkg::valve_pos_t       want;

  assign cmd_one = to_half_steps(s1_demand_one);
  assign cmd_two = to_half_steps(s1_demand_two);

  always_comb begin
    mag_one = cmd_one.mag;
    mag_two = cmd_two.mag;
    pos_one = !cmd_one.neg && cmd_one.mag != '0;
    neg_one = cmd_one.neg && cmd_one.mag != '0;
    pos_two = !cmd_two.neg && cmd_two.mag != '0;
    neg_two = cmd_two.neg && cmd_two.mag != '0;
    // opposite signs: the smaller magnitude drops, the second on a tie
    if ((pos_one && neg_two) || (neg_one && pos_two)) begin
      if (cmd_one.mag < cmd_two.mag) begin
        mag_one = '0;
        pos_one = 1'b0;
        neg_one = 1'b0;
      end else begin
        mag_two = '0;
        pos_two = 1'b0;
        neg_two = 1'b0;
      end
    end
    priority if (pos_one || pos_two) begin
      want = dvs_pkg::VALVE_EXTEND;
    end else if (neg_one || neg_two) begin
      want = dvs_pkg::VALVE_RETRACT;
    end else begin
      want = dvs_pkg::VALVE_CLOSE;
    end
  end

  // directional valve: switch only with both steppers closed, once per period
  dvs_pkg::valve_pos_t       valve_position;
  dvs_pkg::valve_pos_t       valve_position_next;
  logic [TIME_BITS-1:0]      valve_last_time;
  logic [TIME_BITS-1:0]      valve_last_time_next;
  logic [TIME_BITS-1:0]      valve_elapsed;
  logic                      valve_change;
  logic                      switch_done;
  logic [dvs_pkg::POS_W-1:0] target_one;
  logic [dvs_pkg::POS_W-1:0] target_two;

  assign valve_elapsed = s1_now - valve_last_time;
  assign switch_done   = CMP_W'(valve_elapsed) >= CMP_W'(switch_period);
  assign valve_change  = want != valve_position;

  always_comb begin
    valve_position_next  = valve_position;
    valve_last_time_next = valve_last_time;
    if (valve_change && first_position == '0 && second_position == '0 && switch_done) begin
      valve_position_next  = want;
      valve_last_time_next = s1_now;
    end
  end

  // a pending valve change parks both steppers
  assign target_one = valve_change ? '0 : dvs_pkg::POS_W'(mag_one);
  assign target_two = valve_change ? '0 : dvs_pkg::POS_W'(mag_two);

  always_ff @(posedge clk) begin
    if (rst) begin
      valve_position  <= dvs_pkg::VALVE_CLOSE;
      valve_last_time <= '0;
    end else if (fire) begin
      valve_position  <= valve_position_next;
      valve_last_time <= valve_last_time_next;
    end
  end

  // relay drive follows the valve position
  assign switch_position = valve_position;
  assign coil_a          = valve_position == dvs_pkg::VALVE_RETRACT;
  assign coil_b          = valve_position == dvs_pkg::VALVE_EXTEND;

  // stepper channels, first then second
  dvs_stepper #(
    .TIME_BITS (TIME_BITS)
  ) u_stepper_one (
    .clk        (clk),
    .rst        (rst),
    .advance    (fire),
    .target     (target_one),
    .now        (s1_now),
    .cfg        (step_cfg),
    .position   (first_position),
    .step_level (first_step_level),
    .direction  (first_direction)
  );

  dvs_stepper #(
    .TIME_BITS (TIME_BITS)
  ) u_stepper_two (
    .clk        (clk),
    .rst        (rst),
    .advance    (fire),
    .target     (target_two),
    .now        (s1_now),
    .cfg        (step_cfg),
    .position   (second_position),
    .step_level (second_step_level),
    .direction  (second_direction)
  );

endmodule

>>> bench/dual_valve_dcv_sequencer_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for dual_valve_dcv_sequencer_top: a scoreboard class
// predicts the stepper and directional valve state after each demand transfer
// depends on dvs_pkg and the sequencer rtl
module dual_valve_dcv_sequencer_top_tb;

  localparam int LONG_HOLD = 250;

  // one result transfer, field by field
  typedef struct packed {
    logic                      first_level;
    logic                      first_dir;
    logic [dvs_pkg::POS_W-1:0] first_pos;
    logic                      second_level;
    logic                      second_dir;
    logic [dvs_pkg::POS_W-1:0] second_pos;
    logic                      coil_a;
    logic                      coil_b;
    logic [1:0]                valve;
  } valve_state_t;

  // predicted sequencer state and the queue of states still to come out
  class valve_state_scoreboard;
    logic [dvs_pkg::STEP_PER_W-1:0]   step_period;
    logic [dvs_pkg::SWITCH_PER_W-1:0] switch_period;
    logic [dvs_pkg::OT_W-1:0]         overtravel;
    logic [dvs_pkg::POS_W-1:0]        max_pos;
    logic [dvs_pkg::POS_W-1:0]        pos [2];
    logic [dvs_pkg::POS_W-1:0]        goal [2];
    logic [dvs_pkg::OT_W-1:0]         ot_left [2];
    logic                             level [2];
    logic                             dir [2];
    logic [31:0]                      step_stamp [2];
    dvs_pkg::valve_pos_t              valve_now;
    logic [31:0]                      valve_stamp;
    logic [1:0]                       coils;
    valve_state_t                     states_due [$];
    int                               errors;
    int                               checked;
    int                               valve_changes;
    int                               overtravel_taken;
    int                               limit_stalls;

    function new();
      step_period   = dvs_pkg::STEP_PERIOD_RESET;
      switch_period = dvs_pkg::SWITCH_PERIOD_RESET;
      overtravel    = dvs_pkg::OVERTRAVEL_RESET;
      max_pos       = dvs_pkg::MAX_POSITION_RESET;
      for (int k = 0; k < 2; k++) begin
        pos[k]        = '0;
        goal[k]       = '0;
        ot_left[k]    = dvs_pkg::OVERTRAVEL_RESET;
        level[k]      = 1'b0;
        dir[k]        = 1'b0;
        step_stamp[k] = '0;
      end
      valve_now        = dvs_pkg::VALVE_CLOSE;
      valve_stamp      = '0;
      coils            = '0;
      errors           = 0;
      checked          = 0;
      valve_changes    = 0;
      overtravel_taken = 0;
      limit_stalls     = 0;
    endfunction

    function void set_register(dvs_pkg::cfg_index_t idx, logic [dvs_pkg::CFG_W-1:0] data);
      case (idx)
        dvs_pkg::CFG_STEP_PERIOD:   step_period   = data[dvs_pkg::STEP_PER_W-1:0];
        dvs_pkg::CFG_SWITCH_PERIOD: switch_period = data[dvs_pkg::SWITCH_PER_W-1:0];
        dvs_pkg::CFG_OVERTRAVEL:    overtravel    = data[dvs_pkg::OT_W-1:0];
        dvs_pkg::CFG_MAX_POSITION:  max_pos       = data[dvs_pkg::POS_W-1:0];
      endcase
    endfunction

    function int pending();
      return states_due.size();
    endfunction

    // q7.8 percent to half-steps, ten per percent, halves away from zero
    function int half_steps(logic [dvs_pkg::DEMAND_W-1:0] raw);
      logic [16:0] mag;
      logic [31:0] scaled;
      int          q;
      mag    = raw[dvs_pkg::DEMAND_W-1] ? 17'h10000 - {1'b0, raw} : {1'b0, raw};
      scaled = {15'd0, mag} * 32'd10 + 32'd128;
      q      = int'(scaled >> 8);
      return raw[dvs_pkg::DEMAND_W-1] ? -q : q;
    endfunction

    // at most one half-step of stepper k toward its goal
    function void step_once(int k, logic [31:0] now);
      bit          over;
      logic [31:0] elapsed;
      over = 1'b0;
      if (pos[k] != goal[k]) begin
        elapsed = now - step_stamp[k];
        if (elapsed < 32'(step_period)) return;
        step_stamp[k] = now;
        if (pos[k] < goal[k]) begin
          if (pos[k] >= max_pos) begin
            limit_stalls++;
            return;
          end
          dir[k] = 1'b0;
          pos[k] = pos[k] + 1'b1;
        end else begin
          dir[k] = 1'b1;
          if (pos[k] == 1 && ot_left[k] != 0) begin
            over = 1'b1;
            ot_left[k] = ot_left[k] - 1'b1;
            overtravel_taken++;
          end else begin
            pos[k] = pos[k] - 1'b1;
          end
        end
        level[k] = ~level[k];
      end
      if (!over) ot_left[k] = overtravel;
    endfunction

    // accepted demand transfer: advance the state and queue the result
    function void note_demand(logic [dvs_pkg::DEMAND_W-1:0] d1,
                              logic [dvs_pkg::DEMAND_W-1:0] d2, logic [31:0] now);
      int                  c1;
      int                  c2;
      dvs_pkg::valve_pos_t want;
      logic [31:0]         elapsed;
      valve_state_t        s;
      c1 = half_steps(d1);
      c2 = half_steps(d2);
      // opposing demands: the smaller one drops out, the second on a tie
      if (c1 > 0 && c2 < 0) begin
        if (c1 < -c2) c1 = 0;
        else c2 = 0;
      end else if (c1 < 0 && c2 > 0) begin
        if (-c1 < c2) c1 = 0;
        else c2 = 0;
      end
      if (c1 > 0 || c2 > 0) want = dvs_pkg::VALVE_EXTEND;
      else if (c1 < 0 || c2 < 0) want = dvs_pkg::VALVE_RETRACT;
      else want = dvs_pkg::VALVE_CLOSE;
      // direction change: steppers close, valve moves once both are shut
      if (valve_now != want) begin
        if (pos[0] == 0 && pos[1] == 0) begin
          elapsed = now - valve_stamp;
          if (elapsed >= 32'(switch_period)) begin
            valve_stamp = now;
            coils = (want == dvs_pkg::VALVE_EXTEND) ? 2'b10 :
                    (want == dvs_pkg::VALVE_RETRACT) ? 2'b01 : 2'b00;
            valve_now = want;
            valve_changes++;
          end
        end
        c1 = 0;
        c2 = 0;
      end
      goal[0] = dvs_pkg::POS_W'(c1 < 0 ? -c1 : c1);
      step_once(0, now);
      goal[1] = dvs_pkg::POS_W'(c2 < 0 ? -c2 : c2);
      step_once(1, now);
      s.first_level  = level[0];
      s.first_dir    = dir[0];
      s.first_pos    = pos[0];
      s.second_level = level[1];
      s.second_dir   = dir[1];
      s.second_pos   = pos[1];
      s.coil_a       = coils[0];
      s.coil_b       = coils[1];
      s.valve        = valve_now;
      states_due.push_back(s);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 20)
          $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_state(valve_state_t got);
      valve_state_t want;
      if (states_due.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no state due", $time);
        return;
      end
      want = states_due.pop_front();
      checked++;
      compare("first_step_level", 32'(want.first_level), 32'(got.first_level));
      compare("first_direction", 32'(want.first_dir), 32'(got.first_dir));
      compare("first_position", 32'(want.first_pos), 32'(got.first_pos));
      compare("second_step_level", 32'(want.second_level), 32'(got.second_level));
      compare("second_direction", 32'(want.second_dir), 32'(got.second_dir));
      compare("second_position", 32'(want.second_pos), 32'(got.second_pos));
      compare("coil_a", 32'(want.coil_a), 32'(got.coil_a));
      compare("coil_b", 32'(want.coil_b), 32'(got.coil_b));
      compare("switch_position", 32'(want.valve), 32'(got.valve));
    endfunction
  endclass

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [dvs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dvs_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [dvs_pkg::DEMAND_W-1:0]  demand_one = '0;
  logic [dvs_pkg::DEMAND_W-1:0]  demand_two = '0;
  logic [31:0]                   now_us = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          first_step_level;
  logic                          first_direction;
  logic [dvs_pkg::POS_W-1:0]     first_position;
  logic                          second_step_level;
  logic                          second_direction;
  logic [dvs_pkg::POS_W-1:0]     second_position;
  logic                          coil_a;
  logic                          coil_b;
  logic [1:0]                    switch_position;

  valve_state_scoreboard sb;
  logic [31:0] now_t = '0;
  int          burst_left = 0;
  int          items_sent = 0;
  int          settings = 0;
  int          hold_asked = 0;

  dual_valve_dcv_sequencer_top u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .demand_one        (demand_one),
    .demand_two        (demand_two),
    .now_us            (now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .first_step_level  (first_step_level),
    .first_direction   (first_direction),
    .first_position    (first_position),
    .second_step_level (second_step_level),
    .second_direction  (second_direction),
    .second_position   (second_position),
    .coil_a            (coil_a),
    .coil_b            (coil_b),
    .switch_position   (switch_position)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // register write at the next edge; the caller lowers cfg_write
  task automatic write_reg(input dvs_pkg::cfg_index_t idx,
                           input logic [dvs_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  task automatic write_settings(input logic [dvs_pkg::CFG_W-1:0] sp,
                                input logic [dvs_pkg::CFG_W-1:0] swp,
                                input logic [dvs_pkg::CFG_W-1:0] ot,
                                input logic [dvs_pkg::CFG_W-1:0] mx);
    write_reg(dvs_pkg::CFG_STEP_PERIOD, sp);
    write_reg(dvs_pkg::CFG_SWITCH_PERIOD, swp);
    write_reg(dvs_pkg::CFG_OVERTRAVEL, ot);
    write_reg(dvs_pkg::CFG_MAX_POSITION, mx);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // one demand transfer, sender idling between bursts
  task automatic send_item(input logic [dvs_pkg::DEMAND_W-1:0] d1,
                           input logic [dvs_pkg::DEMAND_W-1:0] d2, input logic [31:0] t);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(80, 200)) :
                   int'($urandom_range(1, 30));
    end
    in_valid   <= 1'b1;
    demand_one <= d1;
    demand_two <= d2;
    now_us     <= t;
    do @(posedge clk); while (in_stall);
    sb.note_demand(d1, d2, t);
    burst_left--;
    items_sent++;
  endtask

  // advance the clock of the demands, mostly by about one step period
  task automatic offer(input logic [dvs_pkg::DEMAND_W-1:0] d1,
                       input logic [dvs_pkg::DEMAND_W-1:0] d2);
    int unsigned r;
    logic [31:0] sp;
    sp = 32'(sb.step_period);
    r  = $urandom_range(0, 19);
    if (r == 1) now_t += $urandom;
    else if (r >= 6) now_t += sp + $urandom_range(0, sp / 2 + 2);
    else if (r >= 2) now_t += $urandom_range(0, sp);
    send_item(d1, d2, now_t);
  endtask

  function automatic logic [dvs_pkg::DEMAND_W-1:0] signed_raw(bit neg, int unsigned mag);
    return neg ? dvs_pkg::DEMAND_W'(-mag) : dvs_pkg::DEMAND_W'(mag);
  endfunction

  // drain: wait for every state due, then the pipeline latency
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_segment(input int unsigned cap);
    int unsigned kind;
    int unsigned m1;
    int unsigned m2;
    bit          neg;
    kind = $urandom_range(0, 9);
    m1   = $urandom_range(0, cap);
    m2   = $urandom_range(0, cap);
    neg  = 1'($urandom_range(0, 1));
    if (kind <= 5) begin
      // hold one direction, then close down with near-zero demands
      if ($urandom_range(0, 3) == 0) m2 = 0;
      else if ($urandom_range(0, 3) == 0) m1 = 0;
      repeat ($urandom_range(5, 60))
        offer(signed_raw(neg, m1 + $urandom_range(0, 20)),
              signed_raw(neg, m2 + $urandom_range(0, 20)));
      repeat ($urandom_range(5, 70))
        offer(dvs_pkg::DEMAND_W'($urandom_range(0, 24)) - 16'd12,
              dvs_pkg::DEMAND_W'($urandom_range(0, 24)) - 16'd12);
    end else if (kind <= 7) begin
      // opposing demands, ties now and then
      if ($urandom_range(0, 2) == 0) m2 = m1;
      repeat ($urandom_range(5, 30)) offer(signed_raw(neg, m1), signed_raw(!neg, m2));
    end else if (kind == 8) begin
      repeat ($urandom_range(1, 10))
        offer(dvs_pkg::DEMAND_W'($urandom), dvs_pkg::DEMAND_W'($urandom));
    end else begin
      // broken sequences: short runs that flip direction
      repeat ($urandom_range(2, 6)) begin
        neg = 1'($urandom_range(0, 1));
        m1  = $urandom_range(0, cap);
        m2  = $urandom_range(0, cap);
        repeat ($urandom_range(1, 8)) offer(signed_raw(neg, m1), signed_raw(neg, m2));
      end
    end
  endtask

  task automatic run_phase(input logic [dvs_pkg::CFG_W-1:0] sp,
                           input logic [dvs_pkg::CFG_W-1:0] swp,
                           input logic [dvs_pkg::CFG_W-1:0] ot,
                           input logic [dvs_pkg::CFG_W-1:0] mx,
                           input int count, input bit long_hold);
    int          stop_at;
    int unsigned cap;
    wait_idle();
    write_settings(sp, swp, ot, mx);
    now_t = $urandom;
    cap = unsigned'((int'(sb.max_pos) + 8) * 26);
    if (cap > 32747) cap = 32747;
    if (long_hold) begin
      burst_left = 300;
      hold_asked++;
    end
    stop_at = items_sent + count;
    while (items_sent < stop_at) run_segment(cap);
  endtask

  // receiver: stall patterns of its own, plus one long hold on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    int hold_served;
    tick        = 0;
    hold_served = 0;
    forever begin
      if (hold_asked != hold_served) begin
        hold_served = hold_asked;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      while (span > 0 && hold_asked == hold_served) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 99) < 30);
          2:       out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= (tick % 5 < 2);
        endcase
        tick++;
        span--;
        @(posedge clk);
      end
    end
  end

  // result transfers against the predicted states
  always @(posedge clk) begin : result_watch
    valve_state_t got;
    if (!rst && out_valid && !out_stall) begin
      got.first_level  = first_step_level;
      got.first_dir    = first_direction;
      got.first_pos    = first_position;
      got.second_level = second_step_level;
      got.second_dir   = second_direction;
      got.second_pos   = second_position;
      got.coil_a       = coil_a;
      got.coil_b       = coil_b;
      got.valve        = switch_position;
      sb.check_state(got);
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: rounding, ties, opposing signs, overtravel, limit, time wrap
    write_settings(24'd1, 24'd1, 24'd2, 24'd3);
    send_item(16'sd0, 16'sd0, 32'd10);
    send_item(16'sd64, 16'sd0, 32'd20);
    send_item(16'sd64, 16'sd0, 32'd30);
    send_item(16'sh7FFF, 16'sd64, 32'd40);
    send_item(16'sh7FFF, 16'sh8000, 32'd50);
    send_item(16'sh7FFF, 16'sd63, 32'd60);
    send_item(-16'sd64, 16'sd0, 32'd60);
    for (int i = 0; i < 7; i++) send_item(-16'sd64, 16'sd0, 32'd70 + 32'd10 * i);
    send_item(-16'sd64, 16'sd64, 32'd140);
    send_item(-16'sd63, 16'sd12, 32'd150);
    send_item(16'sd13, -16'sd13, 32'd160);
    send_item(16'sh8000, 16'sh8000, 32'd170);
    send_item(-16'sd1, -16'sd1, 32'd180);
    send_item(-16'sd1, -16'sd1, 32'hFFFF_FFF0);
    send_item(-16'sd1, -16'sd1, 32'h0000_0005);
    send_item(16'sh7FFF, 16'sd1, 32'hFFFF_FFFF);
    send_item(16'sd0, 16'sd0, 32'd0);

    // random phases, register extremes and masked write data among them
    run_phase(24'd0, 24'd0, 24'd0, 24'd4095, 240, 1'b0);
    run_phase(24'd1, 24'd6, 24'd4, 24'd60, 240, 1'b1);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 24'd255, 24'd1, 240, 1'b0);
    run_phase(24'd3, 24'd40, 24'd1, 24'd0, 240, 1'b0);
    run_phase(24'hA00002, 24'h000011, 24'h5A5A09, 24'h3C301E, 240, 1'b0);
    run_phase(24'd1210, 24'd333333, 24'd4, 24'd1000, 240, 1'b0);
    wait_idle();

    $display("checked %0d result transfers under %0d register settings", sb.checked, settings);
    $display("%0d valve changes, %0d overtravel half-steps, %0d opening steps held at the limit",
             sb.valve_changes, sb.overtravel_taken, sb.limit_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("tb: failure");
    $finish;
  end

endmodule
